FILE: sv/battery_gauge_level_smoother_unit_macros.svh
// Assertion macros for the battery gauge level smoother.
// Used by the top level only; needs a clock and a reset signal in scope.
`ifndef BATTERY_GAUGE_LEVEL_SMOOTHER_UNIT_MACROS_SVH
`define BATTERY_GAUGE_LEVEL_SMOOTHER_UNIT_MACROS_SVH

// same-cycle implication
`define BGLS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BGLS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/bgls_pkg.sv
// Shared types and constants of the battery gauge level smoother.
// No dependencies.
package bgls_pkg;

   typedef logic [2:0] level_type;

   // request codes
   localparam logic REQ_TICK   = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   // register indexes
   localparam logic [2:0] CSR_FULL_MV    = 3'd0;
   localparam logic [2:0] CSR_ONE_BAR_MV = 3'd1;
   localparam logic [2:0] CSR_TWO_BAR_MV = 3'd2;
   localparam logic [2:0] CSR_ONE_BAR_EN = 3'd3;
   localparam logic [2:0] CSR_FAR_TICKS  = 3'd4;
   localparam logic [2:0] CSR_NEAR_TICKS = 3'd5;

   // register reset values
   localparam logic [15:0] RST_FULL_MV    = 16'd16000;
   localparam logic [15:0] RST_ONE_BAR_MV = 16'd8000;
   localparam logic [15:0] RST_TWO_BAR_MV = 16'd9000;
   localparam logic        RST_ONE_BAR_EN = 1'b1;
   localparam logic [15:0] RST_FAR_TICKS  = 16'd1000;
   localparam logic [15:0] RST_NEAR_TICKS = 16'd5000;

   // interpolation: level = base + (d * MUL + BIAS) / STEP, capped at LEVEL_MAX
   localparam int NUM_W     = 19;
   localparam int ONE_MUL   = 6;
   localparam int ONE_BIAS  = 4000;
   localparam int ONE_STEP  = 8000;
   localparam int TWO_MUL   = 5;
   localparam int TWO_BIAS  = 3500;
   localparam int TWO_STEP  = 7000;
   localparam int LEVEL_MAX = 7;
   localparam level_type LEVEL_FULL = level_type'(LEVEL_MAX);
   localparam level_type LEVEL_ONE  = 3'd1;
   localparam level_type LEVEL_TWO  = 3'd2;
   localparam level_type LEVEL_NONE = 3'd0;

   typedef struct packed {
      logic [15:0] full_mv;
      logic [15:0] one_mv;
      logic [15:0] two_mv;
      logic        one_en;
      logic [15:0] far_ticks;
      logic [15:0] near_ticks;
   } cfg_type;

   // beat between the level stage and the tracking stage
   typedef struct packed {
      logic      req_type;
      level_type target;
   } tgt_beat_type;

endpackage

FILE: sv/battery_gauge_level_smoother_unit.sv
// Battery gauge level smoother, top level.
// Depends on bgls_pkg, bgls_csr, bgls_level, bgls_track and the macros header.
//
// Usage:
//  - req_ channel: one beat is a 1 ms tick (req_type = 0) or a voltage
//    sample in mV (req_type = 1). Accepted when req_valid && !req_stall.
//  - rsp_ channel: exactly one result beat per request beat, in order:
//    shown level, low warning flag, and whether the display was refreshed.
//    Taken when rsp_valid && !rsp_stall.
//  - csr_ channel: register writes (index, data), always ready. Write only
//    while no beat is in flight.
//  - Pipeline: 2 register stages. Throughput: one beat per cycle while
//    results are taken without stall; stage 1 maps voltage to a target
//    level, stage 2 runs the timer/level update and holds the result register.
//  - Stall: while a result waits, stage 1 can still take one more beat;
//    req_stall rises only when both stages are full and rsp_stall is high.
//  - Reset (synchronous): registers back to defaults, timer and level 0,
//    no sample seen yet, no beats in flight.
module battery_gauge_level_smoother_unit (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [15:0] req_voltage_mv,
   // result
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_shown_level,
   output logic        rsp_low_warning,
   output logic        rsp_display_update,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

`include "battery_gauge_level_smoother_unit_macros.svh"

   bgls_pkg::cfg_type      cfg;
   bgls_pkg::tgt_beat_type s1_beat;
   logic                   s1_valid;
   logic                   advance;   // result register free or being taken
   logic                   s1_load;

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = s1_valid && !advance;
   assign s1_load   = req_valid && !req_stall;

   bgls_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // stage 1: target level
   bgls_level u_level (
      .clock          (clock),
      .reset          (reset),
      .load           (s1_load),
      .drain          (advance),
      .req_type       (req_type),
      .req_voltage_mv (req_voltage_mv),
      .cfg            (cfg),
      .beat_valid     (s1_valid),
      .beat           (s1_beat)
   );

   // stage 2: smoothing state and result register
   bgls_track u_track (
      .clock              (clock),
      .reset              (reset),
      .advance            (advance),
      .beat_valid         (s1_valid),
      .beat               (s1_beat),
      .cfg                (cfg),
      .rsp_valid          (rsp_valid),
      .rsp_shown_level    (rsp_shown_level),
      .rsp_low_warning    (rsp_low_warning),
      .rsp_display_update (rsp_display_update)
   );

   // a refresh always leaves the warning matching an empty gauge
   `BGLS_ASSERT_IMP(a_warn_on_update, rsp_valid && rsp_display_update, rsp_low_warning == (rsp_shown_level == 3'd0), "warning disagrees with refreshed level")
   // a stage-1 beat that moves on must show up as a result
   `BGLS_ASSERT_NEXT(a_beat_to_rsp, s1_valid && advance, rsp_valid, "stage 1 beat lost")
   // no result appears without a beat behind it
   `BGLS_ASSERT_IMP(a_no_phantom, $rose(rsp_valid), $past(s1_valid), "result without a request beat")

endmodule

FILE: sv/bgls_csr.sv
// Configuration registers of the battery gauge level smoother.
// Depends on bgls_pkg.
module bgls_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_wdata,
   output bgls_pkg::cfg_type cfg
);

   bgls_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            bgls_pkg::CSR_FULL_MV:    cfg_in.full_mv    = csr_wdata;
            bgls_pkg::CSR_ONE_BAR_MV: cfg_in.one_mv     = csr_wdata;
            bgls_pkg::CSR_TWO_BAR_MV: cfg_in.two_mv     = csr_wdata;
            bgls_pkg::CSR_ONE_BAR_EN: cfg_in.one_en     = csr_wdata[0];
            bgls_pkg::CSR_FAR_TICKS:  cfg_in.far_ticks  = csr_wdata;
            bgls_pkg::CSR_NEAR_TICKS: cfg_in.near_ticks = csr_wdata;
            default: ;  // unmapped index, ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.full_mv    <= bgls_pkg::RST_FULL_MV;
         cfg_ff.one_mv     <= bgls_pkg::RST_ONE_BAR_MV;
         cfg_ff.two_mv     <= bgls_pkg::RST_TWO_BAR_MV;
         cfg_ff.one_en     <= bgls_pkg::RST_ONE_BAR_EN;
         cfg_ff.far_ticks  <= bgls_pkg::RST_FAR_TICKS;
         cfg_ff.near_ticks <= bgls_pkg::RST_NEAR_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: sv/bgls_level.sv
// Input stage: maps a voltage sample to a target level and registers it.
// Depends on bgls_pkg.
module bgls_level (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic                   drain,
   input  logic                   req_type,
   input  logic [15:0]            req_voltage_mv,
   input  bgls_pkg::cfg_type      cfg,
   output logic                   beat_valid,
   output bgls_pkg::tgt_beat_type beat
);

   logic                   valid_ff, valid_in;
   bgls_pkg::tgt_beat_type beat_ff, beat_in;

   logic [15:0]                  d_one, d_two;
   logic [bgls_pkg::NUM_W-1:0]   num_one, num_two;
   logic [2:0]                   q_one, q_two;
   bgls_pkg::level_type          target;

   assign d_one   = req_voltage_mv - cfg.one_mv;
   assign d_two   = req_voltage_mv - cfg.two_mv;
   assign num_one = bgls_pkg::NUM_W'(d_one) * bgls_pkg::NUM_W'(bgls_pkg::ONE_MUL)
                  + bgls_pkg::NUM_W'(bgls_pkg::ONE_BIAS);
   assign num_two = bgls_pkg::NUM_W'(d_two) * bgls_pkg::NUM_W'(bgls_pkg::TWO_MUL)
                  + bgls_pkg::NUM_W'(bgls_pkg::TWO_BIAS);

   // quotient by constant step, counted against the thresholds up to the cap
   always_comb begin
      q_one = 3'd0;
      q_two = 3'd0;
      for (int k = 1; k <= bgls_pkg::LEVEL_MAX - 1; k++) begin
         if (num_one >= bgls_pkg::NUM_W'(k * bgls_pkg::ONE_STEP)) q_one = q_one + 3'd1;
      end
      for (int k = 1; k <= bgls_pkg::LEVEL_MAX - 2; k++) begin
         if (num_two >= bgls_pkg::NUM_W'(k * bgls_pkg::TWO_STEP)) q_two = q_two + 3'd1;
      end
   end

   always_comb begin
      if (req_voltage_mv >= cfg.full_mv) begin
         target = bgls_pkg::LEVEL_FULL;
      end else if (cfg.one_en && (req_voltage_mv >= cfg.one_mv)) begin
         target = bgls_pkg::LEVEL_ONE + q_one;
      end else if (req_voltage_mv >= cfg.two_mv) begin
         target = bgls_pkg::LEVEL_TWO + q_two;
      end else begin
         target = bgls_pkg::LEVEL_NONE;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (load) begin
         valid_in         = 1'b1;
         beat_in.req_type = req_type;
         beat_in.target   = target;
      end else if (drain) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

endmodule

FILE: sv/bgls_track.sv
// Tracking stage: wait timer, shown level, warning flag and result register.
// Depends on bgls_pkg.
module bgls_track (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   beat_valid,
   input  bgls_pkg::tgt_beat_type beat,
   input  bgls_pkg::cfg_type      cfg,
   output logic                   rsp_valid,
   output logic [2:0]             rsp_shown_level,
   output logic                   rsp_low_warning,
   output logic                   rsp_display_update
);

   logic                started_ff, started_in;
   logic [15:0]         timer_ff, timer_in;
   bgls_pkg::level_type level_ff, level_in;
   logic                warn_ff, warn_in;
   logic                valid_ff, valid_in;
   logic                upd_ff, upd_in;

   bgls_pkg::level_type disp, diff;
   logic                warn0, upd0, step;
   logic                take;

   assign take = advance && beat_valid;

   always_comb begin
      // first sample sets the level directly
      disp  = started_ff ? level_ff : beat.target;
      warn0 = started_ff ? warn_ff : (warn_ff || (beat.target == bgls_pkg::LEVEL_NONE));
      upd0  = !started_ff;
      diff  = (beat.target > disp) ? beat.target - disp : disp - beat.target;
      step  = ((diff >= 3'd2) && (timer_ff >= cfg.far_ticks)) ||
              ((diff == 3'd1) && (timer_ff >= cfg.near_ticks));

      started_in = started_ff;
      timer_in   = timer_ff;
      level_in   = level_ff;
      warn_in    = warn_ff;
      upd_in     = upd_ff;
      valid_in   = advance ? beat_valid : valid_ff;

      if (take) begin
         if (beat.req_type == bgls_pkg::REQ_TICK) begin
            if (timer_ff != 16'hFFFF) timer_in = timer_ff + 16'd1;
            upd_in = 1'b0;
         end else begin
            started_in = 1'b1;
            level_in   = disp;
            warn_in    = warn0;
            upd_in     = upd0;
            if (diff == 3'd0) begin
               timer_in = 16'd0;
            end else if (step) begin
               timer_in = 16'd0;
               level_in = (disp < beat.target) ? disp + 3'd1 : disp - 3'd1;
               warn_in  = (level_in == bgls_pkg::LEVEL_NONE);
               upd_in   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         timer_ff   <= 16'd0;
         level_ff   <= bgls_pkg::LEVEL_NONE;
         warn_ff    <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         started_ff <= started_in;
         timer_ff   <= timer_in;
         level_ff   <= level_in;
         warn_ff    <= warn_in;
         valid_ff   <= valid_in;
      end
      upd_ff <= upd_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_shown_level    = level_ff;
   assign rsp_low_warning    = warn_ff;
   assign rsp_display_update = upd_ff;

endmodule

FILE: sim/battery_gauge_level_smoother_unit_tb.sv
// Self-checking testbench for battery_gauge_level_smoother_unit.
// Uses bgls_pkg and the unit's RTL; predicts each result beat from its own
// model of the gauge and checks it while both channels idle at random.
module battery_gauge_level_smoother_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // csr_index values past the last register; writes there must be dropped
   localparam logic [2:0] CSR_SPARE_A = 3'd6;
   localparam logic [2:0] CSR_SPARE_B = 3'd7;

   localparam int MAX_IDLE     = 12;    // longest gap or stall per beat
   localparam int SETTLE_CYC   = 4;     // pipeline is 2 deep, keep some margin
   localparam int REPORT_LIMIT = 10;
   localparam int PHASES       = 9;
   localparam int PHASE_BEATS  = 45;
   localparam int HOLD_TICKS   = 19;    // one short of the period below
   localparam logic [15:0] HOLD_PERIOD = 16'd20;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_type;
   logic [15:0] req_voltage_mv;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_shown_level;
   logic        rsp_low_warning;
   logic        rsp_display_update;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   battery_gauge_level_smoother_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_voltage_mv     (req_voltage_mv),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_shown_level    (rsp_shown_level),
      .rsp_low_warning    (rsp_low_warning),
      .rsp_display_update (rsp_display_update),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // one result beat as the display sees it
   typedef struct packed {
      bgls_pkg::level_type level;
      logic                warn;
      logic                refresh;
   } reading_type;

   // --------------------------------------------------------------------
   // Gauge model: register copy plus timer, shown level, first-sample flag
   // and warning flag. Updated in accept order, so it stays in step with
   // the pipeline no matter how the two channels stall.
   // --------------------------------------------------------------------
   bgls_pkg::cfg_type   gauge_cfg;
   logic [15:0]         tick_count;
   bgls_pkg::level_type shown;
   logic                seen_sample;
   logic                warn_on;

   reading_type pending_readings[$];   // expected beats, oldest first
   int          mismatches;
   bit          send_gaps_on;          // sender idles between beats
   bit          rsp_stalls_on;         // receiver stalls between beats
   int          rsp_hold;              // stall cycles left before next take

   // Map a voltage to the bar count it deserves. Checks run in fixed order
   // on purpose: thresholds out of order are not sanitized.
   function automatic bgls_pkg::level_type target_of(logic [15:0] mv);
      int unsigned span;
      int unsigned bars;
      if (mv >= gauge_cfg.full_mv) return bgls_pkg::LEVEL_FULL;
      if (gauge_cfg.one_en && mv >= gauge_cfg.one_mv) begin
         span = mv - gauge_cfg.one_mv;
         bars = 1 + (span * bgls_pkg::ONE_MUL + bgls_pkg::ONE_BIAS) / bgls_pkg::ONE_STEP;
         return (bars > bgls_pkg::LEVEL_MAX) ? bgls_pkg::LEVEL_FULL
                                             : bgls_pkg::level_type'(bars);
      end
      if (mv >= gauge_cfg.two_mv) begin
         span = mv - gauge_cfg.two_mv;
         bars = 2 + (span * bgls_pkg::TWO_MUL + bgls_pkg::TWO_BIAS) / bgls_pkg::TWO_STEP;
         return (bars > bgls_pkg::LEVEL_MAX) ? bgls_pkg::LEVEL_FULL
                                             : bgls_pkg::level_type'(bars);
      end
      return bgls_pkg::LEVEL_NONE;
   endfunction

   // Apply one accepted beat to the model and return what the display shows.
   function automatic reading_type advance_gauge(logic kind, logic [15:0] mv);
      bgls_pkg::level_type tgt;
      bgls_pkg::level_type delta;
      logic                refresh;
      refresh = 1'b0;
      if (kind == bgls_pkg::REQ_TICK) begin
         if (tick_count != 16'hFFFF) tick_count++;   // saturates, no wrap
      end else begin
         tgt = target_of(mv);
         if (!seen_sample) begin
            // first sample jumps straight there; warning set here if the target is empty
            seen_sample = 1'b1;
            shown       = tgt;
            if (tgt == bgls_pkg::LEVEL_NONE) warn_on = 1'b1;
            refresh = 1'b1;
         end
         delta = (tgt > shown) ? tgt - shown : shown - tgt;
         if (delta == 0) begin
            tick_count = '0;
         end else if ((delta >= 2 && tick_count >= gauge_cfg.far_ticks) ||
                      (delta == 1 && tick_count >= gauge_cfg.near_ticks)) begin
            tick_count = '0;
            shown      = (shown < tgt) ? shown + 1'b1 : shown - 1'b1;
            warn_on    = (shown == bgls_pkg::LEVEL_NONE);
            refresh    = 1'b1;
         end
      end
      return '{level: shown, warn: warn_on, refresh: refresh};
   endfunction

   // --------------------------------------------------------------------
   // Clock and receiver side
   // --------------------------------------------------------------------
   always #2 clock = ~clock;

   // rsp_stall follows the hold count drawn at each taken beat
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold  <= rsp_hold - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Every taken result beat is compared against the oldest expectation.
   always @(posedge clock) begin : check_results
      reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            if (mismatches < REPORT_LIMIT)
               $display("%0t: unexpected result beat level=%0d warn=%0d upd=%0d",
                        $realtime, rsp_shown_level, rsp_low_warning,
                        rsp_display_update);
            mismatches++;
         end else begin
            want = pending_readings.pop_front();
            if (rsp_shown_level !== want.level || rsp_low_warning !== want.warn ||
                rsp_display_update !== want.refresh) begin
               if (mismatches < REPORT_LIMIT)
                  $display("%0t: mismatch level %0d/%0d warn %0d/%0d upd %0d/%0d %s",
                           $realtime, want.level, rsp_shown_level, want.warn,
                           rsp_low_warning, want.refresh, rsp_display_update,
                           "(expected/actual)");
               mismatches++;
            end
         end
         rsp_hold <= rsp_stalls_on ? int'($urandom_range(0, MAX_IDLE)) : 0;
      end
   end

   // --------------------------------------------------------------------
   // Sender side. All tasks start and end on a falling edge.
   // --------------------------------------------------------------------

   // Send one request beat; the model is advanced at the accepting edge.
   task automatic send_beat(input logic kind, input logic [15:0] mv);
      int gap;
      gap = send_gaps_on ? int'($urandom_range(0, MAX_IDLE)) : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      = 1'b1;
      req_type       = kind;
      req_voltage_mv = mv;
      do @(posedge clock); while (req_stall);
      pending_readings.push_back(advance_gauge(kind, mv));
      @(negedge clock);
   endtask

   // Hold the sender until every expected beat is back and the pipe is empty.
   task automatic drain_readings();
      req_valid = 1'b0;
      while (pending_readings.size() != 0) @(negedge clock);
      repeat (SETTLE_CYC) @(negedge clock);
   endtask

   // Register write; only called with nothing in flight.
   task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         bgls_pkg::CSR_FULL_MV:    gauge_cfg.full_mv    = data;
         bgls_pkg::CSR_ONE_BAR_MV: gauge_cfg.one_mv     = data;
         bgls_pkg::CSR_TWO_BAR_MV: gauge_cfg.two_mv     = data;
         bgls_pkg::CSR_ONE_BAR_EN: gauge_cfg.one_en     = data[0];
         bgls_pkg::CSR_FAR_TICKS:  gauge_cfg.far_ticks  = data;
         bgls_pkg::CSR_NEAR_TICKS: gauge_cfg.near_ticks = data;
         default: ;      // spare indexes are ignored
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
      @(negedge clock);
   endtask

   // --------------------------------------------------------------------
   // Tests
   // --------------------------------------------------------------------

   // Reset defaults: a tick ignores its voltage, the first sample (empty
   // battery) jumps at once and raises the warning, later ones wait.
   task automatic test_first_sample();
      send_beat(bgls_pkg::REQ_TICK, 16'hFFFF);
      send_beat(bgls_pkg::REQ_SAMPLE, 16'd0);
      send_beat(bgls_pkg::REQ_SAMPLE, 16'd7999);   // same target, timer clears
      send_beat(bgls_pkg::REQ_SAMPLE, 16'hFFFF);   // far off but timer not there yet
   endtask

   // Zero periods: every differing sample steps at once. Walk the exact
   // threshold edges with the one-bar branch on, then off.
   task automatic test_thresholds();
      drain_readings();
      write_reg(bgls_pkg::CSR_FAR_TICKS, 16'd0);
      write_reg(bgls_pkg::CSR_NEAR_TICKS, 16'd0);
      send_beat(bgls_pkg::REQ_SAMPLE, 16'hFFFF);   // step off zero clears warning
      send_beat(bgls_pkg::REQ_SAMPLE, 16'd16000);
      send_beat(bgls_pkg::REQ_SAMPLE, 16'd15999);
      send_beat(bgls_pkg::REQ_SAMPLE, 16'd8000);
      send_beat(bgls_pkg::REQ_SAMPLE, 16'd7999);
      drain_readings();
      write_reg(bgls_pkg::CSR_ONE_BAR_EN, 16'd0);
      send_beat(bgls_pkg::REQ_SAMPLE, 16'd8000);   // below two-bar start, target 0
      send_beat(bgls_pkg::REQ_SAMPLE, 16'd12500);
      send_beat(bgls_pkg::REQ_SAMPLE, 16'd9000);
   endtask

   // Thresholds out of order, spare register indexes, stray enable bits.
   task automatic test_out_of_order();
      drain_readings();
      write_reg(bgls_pkg::CSR_FULL_MV, 16'd0);     // everything reads as full
      write_reg(CSR_SPARE_A, 16'hFFFF);
      write_reg(CSR_SPARE_B, 16'hFFFF);
      send_beat(bgls_pkg::REQ_SAMPLE, 16'd0);
      drain_readings();
      write_reg(bgls_pkg::CSR_FULL_MV, 16'hFFFF);
      write_reg(bgls_pkg::CSR_ONE_BAR_MV, 16'd60000);
      write_reg(bgls_pkg::CSR_TWO_BAR_MV, 16'd0);
      write_reg(bgls_pkg::CSR_ONE_BAR_EN, 16'hFFFF); // only bit 0 counts
      send_beat(bgls_pkg::REQ_SAMPLE, 16'd100);
      send_beat(bgls_pkg::REQ_SAMPLE, 16'd60000);
      send_beat(bgls_pkg::REQ_SAMPLE, 16'hFFFF);
   endtask

   // Short far/near periods: samples before and after the timer gets there.
   task automatic test_periods();
      drain_readings();
      write_reg(bgls_pkg::CSR_FULL_MV, bgls_pkg::RST_FULL_MV);
      write_reg(bgls_pkg::CSR_ONE_BAR_MV, bgls_pkg::RST_ONE_BAR_MV);
      write_reg(bgls_pkg::CSR_TWO_BAR_MV, bgls_pkg::RST_TWO_BAR_MV);
      write_reg(bgls_pkg::CSR_ONE_BAR_EN, 16'(bgls_pkg::RST_ONE_BAR_EN));
      write_reg(bgls_pkg::CSR_FAR_TICKS, 16'd3);
      write_reg(bgls_pkg::CSR_NEAR_TICKS, 16'd5);
      send_beat(bgls_pkg::REQ_SAMPLE, 16'd12000);
      repeat (3) send_beat(bgls_pkg::REQ_TICK, 16'($urandom));
      send_beat(bgls_pkg::REQ_SAMPLE, 16'd12000);
      repeat (2) send_beat(bgls_pkg::REQ_TICK, 16'($urandom));
      send_beat(bgls_pkg::REQ_SAMPLE, 16'd9400);
      repeat (3) send_beat(bgls_pkg::REQ_TICK, 16'($urandom));
      send_beat(bgls_pkg::REQ_SAMPLE, 16'd9400);
   endtask

   // Longer periods: the timer must count every tick, step exactly when it
   // reaches the period and restart from zero after the step.
   task automatic test_timer_limit();
      drain_readings();
      send_gaps_on  = 1'b0;
      rsp_stalls_on = 1'b0;
      write_reg(bgls_pkg::CSR_FULL_MV, 16'd0);
      write_reg(bgls_pkg::CSR_FAR_TICKS, 16'd0);
      write_reg(bgls_pkg::CSR_NEAR_TICKS, 16'd0);
      repeat (8) send_beat(bgls_pkg::REQ_SAMPLE, 16'd0);   // climb to full
      drain_readings();
      write_reg(bgls_pkg::CSR_FULL_MV, 16'hFFFF);
      write_reg(bgls_pkg::CSR_ONE_BAR_EN, 16'd0);
      write_reg(bgls_pkg::CSR_TWO_BAR_MV, 16'd0);
      write_reg(bgls_pkg::CSR_FAR_TICKS, HOLD_PERIOD);
      write_reg(bgls_pkg::CSR_NEAR_TICKS, HOLD_PERIOD);
      send_beat(bgls_pkg::REQ_SAMPLE, 16'hFFFF);           // on target, timer clears
      repeat (HOLD_TICKS) send_beat(bgls_pkg::REQ_TICK, 16'($urandom));
      send_beat(bgls_pkg::REQ_SAMPLE, 16'd0);              // one short, holds
      send_beat(bgls_pkg::REQ_TICK, 16'($urandom));
      send_beat(bgls_pkg::REQ_SAMPLE, 16'd0);              // period reached, steps down
      send_beat(bgls_pkg::REQ_SAMPLE, 16'd0);              // timer restarted, holds
   endtask

   // Random phases: fresh register set per phase (sometimes all extremes),
   // a slowly wandering battery voltage mixed with runs of ticks, random
   // idling on both sides and an occasional full drain mid-phase.
   task automatic test_random();
      int  mv;
      int  anchor;
      bit  extreme;
      for (int p = 0; p < PHASES; p++) begin
         drain_readings();
         extreme = (p == 1) || ($urandom_range(0, 5) == 0);
         if (extreme) begin
            write_reg(bgls_pkg::CSR_FULL_MV,
                      $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
            write_reg(bgls_pkg::CSR_ONE_BAR_MV,
                      $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
            write_reg(bgls_pkg::CSR_TWO_BAR_MV,
                      $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
            write_reg(bgls_pkg::CSR_ONE_BAR_EN, 16'($urandom));
            write_reg(bgls_pkg::CSR_FAR_TICKS,
                      $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
            write_reg(bgls_pkg::CSR_NEAR_TICKS,
                      $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
         end else begin
            write_reg(bgls_pkg::CSR_FULL_MV,    16'($urandom_range(14000, 18000)));
            write_reg(bgls_pkg::CSR_ONE_BAR_MV, 16'($urandom_range(6000, 9000)));
            write_reg(bgls_pkg::CSR_TWO_BAR_MV, 16'($urandom_range(7000, 10000)));
            write_reg(bgls_pkg::CSR_ONE_BAR_EN, 16'($urandom_range(0, 1)));
            write_reg(bgls_pkg::CSR_FAR_TICKS,  16'($urandom_range(0, 8)));
            write_reg(bgls_pkg::CSR_NEAR_TICKS, 16'($urandom_range(0, 20)));
         end
         // phase 2 runs flat out; others idle with a 3-in-4 chance per side
         send_gaps_on  = (p != 2) && ($urandom_range(0, 3) != 0);
         rsp_stalls_on = (p != 2) && ($urandom_range(0, 3) != 0);
         anchor = $urandom_range(0, 20000);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if (n == PHASE_BEATS / 2 && $urandom_range(0, 1) == 0) drain_readings();
            if ($urandom_range(0, 7) == 0)
               anchor = extreme ? int'($urandom_range(0, 65535))
                                : int'($urandom_range(0, 20000));
            if ($urandom_range(0, 99) < 60) begin
               send_beat(bgls_pkg::REQ_TICK, 16'($urandom));
            end else begin
               mv = anchor + int'($urandom_range(0, 1200)) - 600;
               if ($urandom_range(0, 19) == 0) mv = $urandom_range(0, 65535);
               if (mv < 0) mv = 0;
               if (mv > 65535) mv = 65535;
               send_beat(bgls_pkg::REQ_SAMPLE, 16'(mv));
            end
         end
      end
   endtask

   // --------------------------------------------------------------------
   // Main sequence
   // --------------------------------------------------------------------
   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = bgls_pkg::REQ_TICK;
      req_voltage_mv = '0;
      rsp_stall      = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = bgls_pkg::CSR_FULL_MV;
      csr_wdata      = '0;
      rsp_hold       = 0;
      mismatches     = 0;
      send_gaps_on   = 1'b1;
      rsp_stalls_on  = 1'b1;
      gauge_cfg      = '{full_mv: bgls_pkg::RST_FULL_MV,
                         one_mv: bgls_pkg::RST_ONE_BAR_MV,
                         two_mv: bgls_pkg::RST_TWO_BAR_MV,
                         one_en: bgls_pkg::RST_ONE_BAR_EN,
                         far_ticks: bgls_pkg::RST_FAR_TICKS,
                         near_ticks: bgls_pkg::RST_NEAR_TICKS};
      tick_count     = '0;
      shown          = bgls_pkg::LEVEL_NONE;
      seen_sample    = 1'b0;
      warn_on        = 1'b0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_first_sample();
      test_thresholds();
      test_out_of_order();
      test_periods();
      test_timer_limit();
      test_random();

      // everything back, then let the pipe run dry before judging
      drain_readings();
      repeat (2 * SETTLE_CYC) @(posedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Watchdog: the slowest legal run is well under a tenth of this.
   initial begin
      #4_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

FILE: files.f
+incdir+sv
sv/bgls_pkg.sv
sv/bgls_csr.sv
sv/bgls_level.sv
sv/bgls_track.sv
sv/battery_gauge_level_smoother_unit.sv
sim/battery_gauge_level_smoother_unit_tb.sv
